FILE: rtl/core/bitmap_unit_allocator_macros.svh
`ifndef BITMAP_UNIT_ALLOCATOR_MACROS_SVH
`define BITMAP_UNIT_ALLOCATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define BUA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define BUA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");

`endif

FILE: rtl/core/bua_pkg.sv
package bua_pkg;

  // Field widths fixed by the interface
  localparam int UNIT_W = 14;
  localparam int FSB_W  = 13;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = UNIT_W;

  // Bit position inside a bitmap word, wide enough for 64-bit words
  localparam int POS_W = 6;

  localparam int unsigned UNIT_COUNT_RST = 128;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIT  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAME  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_DONE
  } state_e;

  // Result of looking at one bitmap word
  typedef struct packed {
    logic             found;  // a usable clear bit exists
    logic [POS_W-1:0] pos;    // lowest usable clear bit
    logic             cur;    // current value of the selected bit
  } word_eval_t;

  // Limit the programmed unit count to the bitmap size
  function automatic logic [UNIT_W-1:0] clamp_count(input logic [UNIT_W-1:0] cnt,
                                                    input int unsigned max_units);
    logic [UNIT_W-1:0] res;
    res = cnt;
    if (32'(cnt) > max_units) res = UNIT_W'(max_units);
    return res;
  endfunction

endpackage

FILE: rtl/core/bua_ram.sv
module bua_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bua_word.sv
module bua_word import bua_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]         word_i,
  input  logic                         lo_en_i,
  input  logic [$clog2(WORD_BITS)-1:0] lo_bit_i,
  input  logic                         hi_en_i,
  input  logic [$clog2(WORD_BITS)-1:0] hi_bit_i,
  input  logic [$clog2(WORD_BITS)-1:0] sel_bit_i,
  input  logic                         alloc_i,
  input  logic                         set_i,
  output word_eval_t                   eval_o,
  output logic [WORD_BITS-1:0]         wdata_o
);

  localparam int BW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] open_bits;
  logic [BW-1:0]        pos;
  logic                 found;
  logic [BW-1:0]        wbit;
  logic                 wval;

  // Mark clear bits that lie inside the search window
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      open_bits[b] = !word_i[b]
                     && !(lo_en_i && (BW'(b) < lo_bit_i))
                     && !(hi_en_i && (BW'(b) > hi_bit_i));
    end
  end

  // Pick the lowest open bit
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (open_bits[b]) begin
        found = 1'b1;
        pos   = BW'(b);
      end
    end
  end

  // Build the write-back word
  always_comb begin
    wbit    = alloc_i ? pos : sel_bit_i;
    wval    = alloc_i ? 1'b1 : set_i;
    wdata_o = word_i;
    wdata_o[wbit] = wval;
  end

  assign eval_o.found = found;
  assign eval_o.pos   = POS_W'(pos);
  assign eval_o.cur   = word_i[sel_bit_i];

endmodule

FILE: rtl/core/bitmap_unit_allocator.sv
// First-fit bitmap allocator for 1-based unit numbers.
// Input channel (valid/ready): cmd_i selects allocate, mark used or free;
// unit_number_i names the unit for mark and free. Output channel
// (valid/ready): one result per command with result_number_o, status_o and
// free_units_o (free count after the command).
// The used bitmap sits in a word-wide RAM, MAX_UNITS/WORD_BITS words deep.
// A command that fails its range or full check goes from idle straight to
// the done state; mark and free read their word and then modify it; allocate
// scans the bitmap, one RAM word read per cycle, up to
// MAX_UNITS/WORD_BITS words. One command is in flight at a time; control
// returns to idle on the edge that loads the result, so a new command can be
// taken even while the previous result still waits in the output register.
// After reset, and after every write of unit_count, the RAM is cleared one
// word per cycle and in_ready_o stays low meanwhile. A stalled receiver
// holds the result in the output register; the next result then waits
// internally until it drains.
// WORD_BITS must be a power of two.
`include "bitmap_unit_allocator_macros.svh"

module bitmap_unit_allocator import bua_pkg::*; #(
  parameter int MAX_UNITS = 8192,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [UNIT_W-1:0]     unit_number_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [UNIT_W-1:0]     result_number_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [UNIT_W-1:0]     free_units_o
);

  localparam int WORD_COUNT = (MAX_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);

  // Control state
  state_e             state_q, state_d;
  logic [WA_W-1:0]    addr_q, addr_d;
  logic [UNIT_W-1:0]  unit_count_q, unit_count_d;
  logic [FSB_W-1:0]   fsb_q, fsb_d;
  logic [UNIT_W-1:0]  free_q, free_d;
  logic               out_valid_q, out_valid_d;

  // Payload
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [UNIT_W-1:0]  num_q, num_d;
  logic [UNIT_W-1:0]  res_num_q, res_num_d;
  status_e            res_stat_q, res_stat_d;
  logic [UNIT_W-1:0]  out_num_q, out_num_d;
  status_e            out_stat_q, out_stat_d;
  logic [UNIT_W-1:0]  out_free_q, out_free_d;

  // Derived values
  logic [UNIT_W-1:0]  eff_cnt, last_idx, fsb_idx, in_idx, num_idx, scan_idx;
  logic [WA_W-1:0]    fsb_word, last_word, in_word;
  logic [BW-1:0]      fsb_bit, last_bit, sel_bit;
  logic               acc, alloc_none, in_bad, cfg_cnt_wr, out_free, scan_last, want;
  logic               alloc_hit;

  // RAM and word unit
  logic               ram_we, ram_re;
  logic [WA_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, word_wdata;
  word_eval_t         eval;

  assign eff_cnt    = clamp_count(unit_count_q, int'(MAX_UNITS));
  assign last_idx   = eff_cnt - 1'b1;
  assign fsb_idx    = UNIT_W'(fsb_q);
  assign in_idx     = unit_number_i - 1'b1;
  assign num_idx    = num_q - 1'b1;
  assign fsb_word   = WA_W'(fsb_idx >> BW);
  assign fsb_bit    = BW'(fsb_idx);
  assign last_word  = WA_W'(last_idx >> BW);
  assign last_bit   = BW'(last_idx);
  assign in_word    = WA_W'(in_idx >> BW);
  assign sel_bit    = BW'(num_idx);
  assign scan_idx   = (UNIT_W'(addr_q) << BW) | UNIT_W'(eval.pos[BW-1:0]);

  assign acc        = in_valid_i && in_ready_o;
  assign alloc_none = (free_q == '0) || (fsb_idx >= eff_cnt);
  assign in_bad     = (unit_number_i == '0) || (unit_number_i > eff_cnt);
  assign cfg_cnt_wr = cfg_we_i && (cfg_index_i == REG_UNIT_COUNT);
  assign out_free   = !out_valid_q || out_ready_i;
  assign scan_last  = (addr_q == last_word);
  assign want       = (cmd_q == CMD_MARK);
  assign alloc_hit  = (state_q == S_SCAN) && eval.found;

  bua_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bua_word #(
    .WORD_BITS (WORD_BITS)
  ) u_word (
    .word_i    (ram_rdata),
    .lo_en_i   (addr_q == fsb_word),
    .lo_bit_i  (fsb_bit),
    .hi_en_i   (scan_last),
    .hi_bit_i  (last_bit),
    .sel_bit_i (sel_bit),
    .alloc_i   (state_q == S_SCAN),
    .set_i     (want),
    .eval_o    (eval),
    .wdata_o   (word_wdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (addr_q == WA_W'(WORD_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          case (cmd_i)
            CMD_ALLOC:          state_d = alloc_none ? S_DONE : S_SCAN;
            CMD_MARK, CMD_FREE: state_d = in_bad ? S_DONE : S_MODIFY;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (eval.found || scan_last) state_d = S_DONE;
      end
      S_MODIFY: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_cnt_wr) state_d = S_CLEAR;
  end

  // State outputs: handshake and RAM access
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = word_wdata;
    ram_re     = 1'b0;
    ram_raddr  = addr_q + 1'b1;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = acc;
        ram_raddr  = (cmd_i == CMD_ALLOC) ? fsb_word : in_word;
      end
      S_SCAN: begin
        ram_we = eval.found;
        ram_re = !eval.found && !scan_last;
      end
      S_MODIFY: ram_we = (eval.cur != want);
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    addr_d       = addr_q;
    unit_count_d = unit_count_q;
    fsb_d        = fsb_q;
    free_d       = free_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_d        = cmd_q;
    num_d        = num_q;
    res_num_d    = res_num_q;
    res_stat_d   = res_stat_q;
    out_num_d    = out_num_q;
    out_stat_d   = out_stat_q;
    out_free_d   = out_free_q;

    case (state_q)
      S_CLEAR: addr_d = addr_q + 1'b1;
      S_IDLE: begin
        if (acc) begin
          cmd_d     = cmd_i;
          num_d     = unit_number_i;
          res_num_d = '0;
          addr_d    = (cmd_i == CMD_ALLOC) ? fsb_word : in_word;
          case (cmd_i)
            CMD_ALLOC:          res_stat_d = alloc_none ? ST_FULL : ST_OK;
            CMD_MARK, CMD_FREE: res_stat_d = in_bad ? ST_RANGE : ST_OK;
            default:            res_stat_d = ST_RANGE;
          endcase
        end
      end
      S_SCAN: begin
        if (eval.found) begin
          res_num_d  = scan_idx + 1'b1;
          res_stat_d = ST_OK;
          free_d     = free_q - 1'b1;
        end else if (scan_last) begin
          res_stat_d = ST_FULL;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_MODIFY: begin
        if (eval.cur == want) begin
          res_stat_d = ST_SAME;
        end else begin
          res_num_d  = num_q;
          res_stat_d = ST_OK;
          if (want) begin
            if (free_q != '0) free_d = free_q - 1'b1;
          end else begin
            if (free_q < eff_cnt) free_d = free_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_num_d   = res_num_q;
          out_stat_d  = res_stat_q;
          out_free_d  = free_q;
        end
      end
      default: ;
    endcase

    // Register writes; a new unit count restarts the allocator
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_UNIT_COUNT: begin
          unit_count_d = cfg_data_i[UNIT_W-1:0];
          free_d       = clamp_count(cfg_data_i[UNIT_W-1:0], int'(MAX_UNITS));
          addr_d       = '0;
        end
        REG_FIRST_BIT: fsb_d = cfg_data_i[FSB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      unit_count_q <= UNIT_W'(UNIT_COUNT_RST);
      fsb_q        <= '0;
      free_q       <= clamp_count(UNIT_W'(UNIT_COUNT_RST), int'(MAX_UNITS));
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      unit_count_q <= unit_count_d;
      fsb_q        <= fsb_d;
      free_q       <= free_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    num_q      <= num_d;
    res_num_q  <= res_num_d;
    res_stat_q <= res_stat_d;
    out_num_q  <= out_num_d;
    out_stat_q <= out_stat_d;
    out_free_q <= out_free_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_number_o = out_num_q;
  assign status_o        = out_stat_q;
  assign free_units_o    = out_free_q;

  // Free count never exceeds the managed unit count
  `BUA_ASSERT_IMPL(a_free_bounded, 1'b1, free_q <= eff_cnt)
  // A successful allocation takes exactly one unit
  `BUA_ASSERT_NEXT(a_alloc_takes_one, alloc_hit && !cfg_cnt_wr, free_q == $past(free_q) - 1'b1)
  // The scan never walks past the word holding the last unit
  `BUA_ASSERT_IMPL(a_scan_in_bounds, state_q == S_SCAN, addr_q <= last_word)
  // A unit number comes back exactly when the command succeeded
  `BUA_ASSERT_IMPL(a_result_matches_status, out_valid_q, (out_stat_q == ST_OK) == (out_num_q != '0))

endmodule
